>>> src/pjsf_pkg.sv
// ----------------------------------------------------------------------------
// pjsf_pkg
// Shared constants and types for the pressure jump shock flag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pjsf_pkg;

    localparam int DEFAULT_PRESSURE_BITS = 32;
    localparam int ALPHA_BITS            = 24;
    localparam int FRAC_BITS             = 16;
    localparam int NUM_NB                = 6;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET  = 24'd65536;
    localparam logic                  ENABLE_RESET = 1'b0;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_ENABLE = 1'b0,
        CFG_ALPHA  = 1'b1
    } cfg_index_t;

    // load strobes for the lane pipeline stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pjsf_ld_t;

endpackage : pjsf_pkg

`default_nettype wire

>>> src/pressure_jump_shock_flag_unit.sv
// ----------------------------------------------------------------------------
// pressure_jump_shock_flag_unit
// Flags a cell whose pressure jumps too far relative to any face neighbour.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         in_valid/in_stall    p_center, p_*, neighbour_valid
//  output    out        out_valid/out_stall  shock_flag, jump_mask
//  config    in         cfg_we               cfg_index, cfg_wdata
//
//  One request per cycle while out_stall is low; a request passes the difference,
//  split multiply, combine/compare and output register stages to the result.
//  Six lanes run in parallel, one per neighbour; the pipeline closes bubbles
//  so requests keep entering while a result waits on out_stall, until all stages fill.
//  Reset clears the stage valids and sets enable = 0, alpha = 1.0 (Q8.16).
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_jump_shock_flag_unit #(
    parameter int PRESSURE_BITS = pjsf_pkg::DEFAULT_PRESSURE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [PRESSURE_BITS-1:0]        p_center,
    input  wire logic [PRESSURE_BITS-1:0]        p_xminus,
    input  wire logic [PRESSURE_BITS-1:0]        p_xplus,
    input  wire logic [PRESSURE_BITS-1:0]        p_yminus,
    input  wire logic [PRESSURE_BITS-1:0]        p_yplus,
    input  wire logic [PRESSURE_BITS-1:0]        p_zminus,
    input  wire logic [PRESSURE_BITS-1:0]        p_zplus,
    input  wire logic [pjsf_pkg::NUM_NB-1:0]     neighbour_valid,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 shock_flag,
    output logic [pjsf_pkg::NUM_NB-1:0]          jump_mask,

    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [pjsf_pkg::ALPHA_BITS-1:0] cfg_wdata
);
    import pjsf_pkg::*;

    logic                  enable_reg;
    logic [ALPHA_BITS-1:0] alpha_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic out_v;
    logic out_free;
    pjsf_ld_t ld;

    logic [PRESSURE_BITS-1:0] nb [NUM_NB];
    logic [NUM_NB-1:0]        check;
    logic [NUM_NB-1:0]        hits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= ENABLE_RESET;
            alpha_reg  <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLE: enable_reg <= cfg_wdata[0];
                CFG_ALPHA:  alpha_reg  <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    assign out_free = !out_v || !out_stall;
    assign ld.ld3   = !v3_reg || out_free;
    assign ld.ld2   = !v2_reg || ld.ld3;
    assign ld.ld1   = !v1_reg || ld.ld2;
    assign in_stall = !ld.ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld.ld1)
                v1_reg <= in_valid;
            if (ld.ld2)
                v2_reg <= v1_reg;
            if (ld.ld3)
                v3_reg <= v2_reg;
        end
    end

    assign nb[0] = p_xminus;
    assign nb[1] = p_xplus;
    assign nb[2] = p_yminus;
    assign nb[3] = p_yplus;
    assign nb[4] = p_zminus;
    assign nb[5] = p_zplus;
    assign check = neighbour_valid & {NUM_NB{enable_reg}};

    for (genvar i = 0; i < NUM_NB; i++)
    begin : g_lane
        pjsf_lane #(
            .PRESSURE_BITS(PRESSURE_BITS)
        ) u_lane (
            .clk   (clk),
            .ld    (ld),
            .alpha (alpha_reg),
            .p     (p_center),
            .q     (nb[i]),
            .check (check[i]),
            .hit   (hits[i])
        );
    end

    pjsf_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_free),
        .in_v       (v3_reg),
        .hits       (hits),
        .out_v      (out_v),
        .shock_flag (shock_flag),
        .jump_mask  (jump_mask)
    );

    assign out_valid = out_v;

endmodule : pressure_jump_shock_flag_unit

`default_nettype wire

>>> src/pjsf_lane.sv
// ----------------------------------------------------------------------------
// pjsf_lane
// One neighbour comparison: |p-q| * 2^16 > alpha * min(p,q), three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsf_lane #(
    parameter int PRESSURE_BITS = pjsf_pkg::DEFAULT_PRESSURE_BITS
) (
    input  wire logic                            clk,
    input  wire pjsf_pkg::pjsf_ld_t              ld,
    input  wire logic [pjsf_pkg::ALPHA_BITS-1:0] alpha,
    input  wire logic [PRESSURE_BITS-1:0]        p,
    input  wire logic [PRESSURE_BITS-1:0]        q,
    input  wire logic                            check,
    output logic                                 hit
);
    import pjsf_pkg::*;

    localparam int LO_BITS  = (PRESSURE_BITS + 1) / 2;
    localparam int HI_BITS  = PRESSURE_BITS - LO_BITS;
    localparam int PROD_W   = PRESSURE_BITS + ALPHA_BITS;
    localparam int PP_LO_W  = ALPHA_BITS + LO_BITS;
    localparam int PP_HI_W  = ALPHA_BITS + HI_BITS;
    localparam int LHS_W    = PRESSURE_BITS + FRAC_BITS;

    // stage 1: difference and minimum
    logic [PRESSURE_BITS-1:0] diff1_reg, diff1_next;
    logic [PRESSURE_BITS-1:0] min1_reg, min1_next;
    logic                     chk1_reg;

    // stage 2: split product
    logic [PRESSURE_BITS-1:0] diff2_reg;
    logic [PP_LO_W-1:0]       pplo_reg, pplo_next;
    logic [PP_HI_W-1:0]       pphi_reg, pphi_next;
    logic                     chk2_reg;

    // stage 3: combine and compare
    logic                     hit_reg, hit_next;
    logic [PROD_W-1:0]        prod;
    logic [LHS_W-1:0]         lhs;

    always_comb
    begin
        if (p > q)
        begin
            diff1_next = p - q;
            min1_next  = q;
        end
        else
        begin
            diff1_next = q - p;
            min1_next  = p;
        end
    end

    always_comb
    begin
        pplo_next = PP_LO_W'(alpha) * PP_LO_W'(min1_reg[LO_BITS-1:0]);
        pphi_next = PP_HI_W'(alpha) * PP_HI_W'(min1_reg[PRESSURE_BITS-1:LO_BITS]);
    end

    always_comb
    begin
        prod     = PROD_W'(pplo_reg) + (PROD_W'(pphi_reg) << LO_BITS);
        lhs      = {diff2_reg, {FRAC_BITS{1'b0}}};
        hit_next = chk2_reg && (PROD_W'(lhs) > prod);
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld1)
        begin
            diff1_reg <= diff1_next;
            min1_reg  <= min1_next;
            chk1_reg  <= check;
        end
        if (ld.ld2)
        begin
            diff2_reg <= diff1_reg;
            pplo_reg  <= pplo_next;
            pphi_reg  <= pphi_next;
            chk2_reg  <= chk1_reg;
        end
        if (ld.ld3)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule : pjsf_lane

`default_nettype wire

>>> src/pjsf_merge.sv
// ----------------------------------------------------------------------------
// pjsf_merge
// Collects the lane results into the mask and flag and holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pjsf_merge (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic                        in_v,
    input  wire logic [pjsf_pkg::NUM_NB-1:0] hits,
    output logic                             out_v,
    output logic                             shock_flag,
    output logic [pjsf_pkg::NUM_NB-1:0]      jump_mask
);
    import pjsf_pkg::*;

    logic              valid_reg;
    logic              flag_reg, flag_next;
    logic [NUM_NB-1:0] mask_reg;

    assign flag_next = |hits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flag_reg <= flag_next;
            mask_reg <= hits;
        end
    end

    assign out_v      = valid_reg;
    assign shock_flag = flag_reg;
    assign jump_mask  = mask_reg;

endmodule : pjsf_merge

`default_nettype wire

>>> tb/sv/pressure_jump_shock_flag_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_jump_shock_flag_unit_tb
// Streams cell requests through the shock flag unit under bursty input and
// a patterned output stall. A short table of hand-picked cells comes first,
// then random cells weighted towards the threshold edge, over several
// enable/alpha settings. Each result is checked against the table's typed mask
// or a local predictor of the exact |p-q|*2^16 > alpha*min(p,q) comparison.
// ----------------------------------------------------------------------------
module pressure_jump_shock_flag_unit_tb;
    import pjsf_pkg::*;

    localparam int PB               = DEFAULT_PRESSURE_BITS;
    localparam int WIDE             = PB + ALPHA_BITS + 1;
    localparam int LIMIT            = 250000;
    localparam int RANDOM_PER_PHASE = 205;
    localparam int NUM_PHASES       = 8;
    localparam logic [PB-1:0] P_MAX = '1;

    typedef logic [WIDE-1:0] wide_t;

    typedef struct packed {
        logic [PB-1:0]             center;
        logic [NUM_NB-1:0][PB-1:0] nb;
        logic [NUM_NB-1:0]         valid;
    } cell_req_t;

    typedef struct packed {
        cell_req_t             req;
        logic                  en;
        logic [ALPHA_BITS-1:0] alpha;
        logic                  typed;
        logic [NUM_NB-1:0]     typed_mask;
    } table_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    cell_req_t             cell_drv   = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic                  shock_flag;
    logic [NUM_NB-1:0]     jump_mask;
    logic                  cfg_we     = 1'b0;
    logic                  cfg_index  = 1'b0;
    logic [ALPHA_BITS-1:0] cfg_wdata  = '0;

    // local copy of the register file
    logic                  en_now     = ENABLE_RESET;
    logic [ALPHA_BITS-1:0] alpha_now  = ALPHA_RESET;

    logic [NUM_NB-1:0]     jump_due[$];
    table_row_t            directed_rows[$];
    int                    error_count = 0;
    int unsigned           cycle_count = 0;
    int unsigned           burst_left  = 0;
    int unsigned           gap_left    = 0;
    int unsigned           stall_left  = 0;
    int unsigned           stall_mode  = 0;
    int unsigned           stall_tick  = 0;

    pressure_jump_shock_flag_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .p_center        (cell_drv.center),
        .p_xminus        (cell_drv.nb[0]),
        .p_xplus         (cell_drv.nb[1]),
        .p_yminus        (cell_drv.nb[2]),
        .p_yplus         (cell_drv.nb[3]),
        .p_zminus        (cell_drv.nb[4]),
        .p_zplus         (cell_drv.nb[5]),
        .neighbour_valid (cell_drv.valid),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .shock_flag      (shock_flag),
        .jump_mask       (jump_mask),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [NUM_NB-1:0] predict_jumps(cell_req_t c, logic en,
                                                        logic [ALPHA_BITS-1:0] a);
        logic [NUM_NB-1:0] hits;
        logic [PB-1:0]     q;
        logic [PB-1:0]     diff;
        logic [PB-1:0]     low;
        hits = '0;
        if (en)
        begin
            for (int i = 0; i < NUM_NB; i++)
            begin
                q    = c.nb[i];
                diff = (c.center > q) ? c.center - q : q - c.center;
                low  = (c.center < q) ? c.center : q;
                // strict compare at full width; equal pressures never flag
                if (c.valid[i] && ((wide_t'(diff) << FRAC_BITS) > wide_t'(a) * wide_t'(low)))
                    hits[i] = 1'b1;
            end
        end
        return hits;
    endfunction

    // neighbour pressure a step or two either side of the threshold
    function automatic logic [PB-1:0] near_edge(logic [PB-1:0] p, logic [ALPHA_BITS-1:0] a,
                                                logic above);
        wide_t t;
        wide_t q;
        if (above)
        begin
            t = (wide_t'(a) * wide_t'(p)) >> FRAC_BITS;
            q = wide_t'(p) + t + $urandom_range(0, 2) - 1;
        end
        else
        begin
            q = (wide_t'(p) << FRAC_BITS) / (wide_t'(a) + wide_t'(65536));
            q = q + $urandom_range(0, 4) - 2;
        end
        return (q > wide_t'(P_MAX)) ? P_MAX : q[PB-1:0];
    endfunction

    function automatic cell_req_t make_cell(logic [ALPHA_BITS-1:0] a);
        cell_req_t   c;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            c.center = $urandom;
        else if (pick < 17)
            c.center = $urandom_range(0, 20);
        else if (pick < 19)
            c.center = $urandom_range(0, 4095);
        else
            c.center = $urandom_range(0, 1) ? P_MAX : '0;
        for (int i = 0; i < NUM_NB; i++)
        begin
            case ($urandom_range(0, 9)) inside
                0, 1:    c.nb[i] = $urandom;
                2, 3:    c.nb[i] = near_edge(c.center, a, 1'b1);
                4, 5:    c.nb[i] = near_edge(c.center, a, 1'b0);
                6:       c.nb[i] = c.center;
                7:       c.nb[i] = $urandom_range(0, 20);
                8:       c.nb[i] = $urandom_range(0, 1) ? P_MAX : '0;
                default: c.nb[i] = c.center + $urandom_range(0, 6) - 3;
            endcase
        end
        c.valid = $urandom_range(0, 1) ? {NUM_NB{1'b1}} : NUM_NB'($urandom);
        return c;
    endfunction

    task automatic add_row(logic en, logic [ALPHA_BITS-1:0] a, logic [PB-1:0] center,
                           logic [PB-1:0] xm, logic [PB-1:0] xp, logic [PB-1:0] ym,
                           logic [PB-1:0] yp, logic [PB-1:0] zm, logic [PB-1:0] zp,
                           logic [NUM_NB-1:0] v, logic typed, logic [NUM_NB-1:0] tm);
        table_row_t r;
        r.req.center = center;
        r.req.nb     = {zp, zm, yp, ym, xp, xm};
        r.req.valid  = v;
        r.en         = en;
        r.alpha      = a;
        r.typed      = typed;
        r.typed_mask = tm;
        directed_rows.push_back(r);
    endtask

    // one request: optional gap, then hold until accepted
    task automatic send_cell(cell_req_t c, logic typed, logic [NUM_NB-1:0] typed_mask);
        while (gap_left > 0)
        begin
            in_valid = 1'b0;
            @(negedge clk);
            gap_left--;
        end
        cell_drv = c;
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        jump_due.push_back(typed ? typed_mask : predict_jumps(c, en_now, alpha_now));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 6);
        end
    endtask

    // registers change only with the pipe empty
    task automatic set_regs(logic en, logic [ALPHA_BITS-1:0] a);
        in_valid = 1'b0;
        while (jump_due.size() != 0)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_ENABLE;
        cfg_wdata = ALPHA_BITS'(en);
        @(negedge clk);
        cfg_index = CFG_ALPHA;
        cfg_wdata = a;
        @(negedge clk);
        cfg_we    = 1'b0;
        en_now    = en;
        alpha_now = a;
    endtask

    // receiver back-pressure, pattern drawn at random from four modes
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ((stall_tick % 5) < 2);
            default: out_stall <= ($urandom_range(0, 1) == 1);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        logic [NUM_NB-1:0] due;
        if (rst_n && out_valid && !out_stall)
        begin
            if (jump_due.size() == 0)
            begin
                $display("%0t: result with none pending: shock_flag %0b jump_mask %b",
                         $time, shock_flag, jump_mask);
                error_count++;
            end
            else
            begin
                due = jump_due.pop_front();
                if (shock_flag !== (|due))
                begin
                    $display("%0t: shock_flag expected %0b actual %0b",
                             $time, |due, shock_flag);
                    error_count++;
                end
                if (jump_mask !== due)
                begin
                    $display("%0t: jump_mask expected %b actual %b", $time, due, jump_mask);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("pressure_jump_shock_flag_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        table_row_t            row;
        logic [ALPHA_BITS-1:0] one_q;
        one_q = ALPHA_RESET;

        // en  alpha  centre  x-  x+  y-  y+  z-  z+  valid  typed  mask
        // disabled straight out of reset
        add_row(1'b0, one_q, '0, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX, P_MAX,
                6'h3F, 1'b1, 6'b000000);
        add_row(1'b0, one_q, P_MAX, '0, '0, '0, '0, '0, '0, 6'h3F, 1'b1, 6'b000000);
        // zero minimum flags whenever the pair differs
        add_row(1'b1, one_q, '0, '0, 32'd5, '0, P_MAX, '0, 32'd1, 6'h3F, 1'b1, 6'b101010);
        add_row(1'b1, one_q, P_MAX, '0, P_MAX, 32'd1, P_MAX - 1, '0, P_MAX,
                6'h3F, 1'b1, 6'b010101);
        // zero threshold: any nonzero jump flags, equal never does
        add_row(1'b1, '0, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100, 32'd100,
                6'h3F, 1'b1, 6'b000000);
        add_row(1'b1, '0, 32'd100, 32'd101, 32'd99, 32'd100, 32'd100, 32'd100, 32'd100,
                6'h3F, 1'b1, 6'b000011);
        add_row(1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 6'h3F, 1'b1, 6'b000000);
        add_row(1'b1, '0, P_MAX, P_MAX - 1, P_MAX, '0, 32'd1, 32'hAAAA_AAAA, 32'h5555_5555,
                6'h3F, 1'b1, 6'b111101);
        // ratio of exactly 1.0 must not flag
        add_row(1'b1, one_q, 32'd100, 32'd200, 32'd201, 32'd50, 32'd49, 32'd100, '0,
                6'h3F, 1'b1, 6'b101010);
        add_row(1'b1, one_q, 32'd100, 32'd200, 32'd201, 32'd50, 32'd49, 32'd100, '0,
                6'b010101, 1'b1, 6'b000000);
        add_row(1'b1, one_q, 32'd100, 32'd200, 32'd201, 32'd50, 32'd49, 32'd100, '0,
                6'b000000, 1'b1, 6'b000000);
        // one neighbour at a time, alpha 1.5 with edge values either side
        for (int i = 0; i < NUM_NB; i++)
            add_row(1'b1, 24'h018000, 32'd1000, 32'd2500, 32'd2501, 32'd400, 32'd399,
                    32'd1000, P_MAX, NUM_NB'(1 << i), 1'b0, '0);
        // largest threshold
        add_row(1'b1, '1, 32'd1, P_MAX, 32'd256, 32'd257, '0, 32'd1, 32'd2,
                6'h3F, 1'b0, '0);
        add_row(1'b1, '1, P_MAX, '0, P_MAX, 32'h8000_0000, 32'h0100_0000, 32'h00FF_FFFF,
                32'h0001_0000, 6'h3F, 1'b0, '0);
        add_row(1'b0, '1, 32'd5, '0, P_MAX, '0, P_MAX, '0, P_MAX, 6'h3F, 1'b1, 6'b000000);
        add_row(1'b1, one_q, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAB, 32'h2AAA_AAAA,
                32'h2AAA_AAAB, 32'h5555_5554, 32'h5555_5556, 6'h3F, 1'b0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.en != en_now || row.alpha != alpha_now)
                set_regs(row.en, row.alpha);
            send_cell(row.req, row.typed, row.typed_mask);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       set_regs(1'b1, ALPHA_RESET);
                1:       set_regs(1'b1, '0);
                2:       set_regs(1'b1, '1);
                3:       set_regs(1'b1, ALPHA_BITS'($urandom));
                4:       set_regs(1'b0, ALPHA_BITS'($urandom));
                5:       set_regs(1'b1, 24'd1);
                6:       set_regs(1'b1, ALPHA_BITS'($urandom_range(0, 24'h03FFFF)));
                default: set_regs(1'b1, 24'h008000);
            endcase
            repeat (RANDOM_PER_PHASE)
                send_cell(make_cell(alpha_now), 1'b0, '0);
        end

        in_valid = 1'b0;
        while (jump_due.size() != 0)
            @(negedge clk);
        // keep clocking to catch stray results
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("pressure_jump_shock_flag_unit_tb OK");
        else
            $display("pressure_jump_shock_flag_unit_tb NOT OK");
        $finish;
    end

endmodule
